// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the link rate meter.
// Needs nothing else; take it in by `include before the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while the synchronous reset is high.
`define LRM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs across reset.
`define LRM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/lrm_pkg.sv
// Package for the link rate meter: field widths, constants, register
// indexes and the structs passed between the top level and its lanes.
`timescale 1ns / 1ps
`default_nettype none

package lrm_pkg;

   // stream and register port widths
   localparam int REQ_W      = 144;  // 64 + 64 + 16, whole bytes
   localparam int RSP_W      = 192;  // 4*40 + 2*14 = 188, padded to 24 bytes
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // field widths
   localparam int CNT_W   = 64;
   localparam int MS_W    = 16;
   localparam int RATE_W  = 40;
   localparam int PCT_W   = 14;
   localparam int SCALE_W = 48;
   localparam int MINMS_W = 10;
   localparam int FLOOR_W = 32;
   localparam int HEAD_W  = 18;
   localparam int DECAY_W = 17;
   localparam int RSP_PAD_W = RSP_W - (4 * RATE_W + 2 * PCT_W);

   // serial multiplier: 54-bit multiplicand, 18-bit multiplier
   localparam int MUL_S_W = 54;
   localparam int MUL_F_W = 18;
   localparam int Q_FRAC  = 16;

   localparam logic [RATE_W-1:0]  RATE_MAX    = '1;
   localparam logic [SCALE_W-1:0] SCALE_MAX   = '1;
   localparam logic [PCT_W-1:0]   PCT_FULL    = PCT_W'(10000);
   localparam logic [MUL_F_W-1:0] K_MS_PER_S  = MUL_F_W'(1000);
   localparam logic [MUL_F_W-1:0] K_PCT_SCALE = MUL_F_W'(10000);

   // register reset values
   localparam logic [MINMS_W-1:0] MINMS_RESET = MINMS_W'(10);
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1000);
   localparam logic [HEAD_W-1:0]  HEAD_RESET  = HEAD_W'(78643);
   localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(64881);
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_ELAPSED = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_FLOOR = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEADROOM    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY       = 2'd3;

   typedef struct packed {
      logic [FLOOR_W-1:0] scale_floor;
      logic [HEAD_W-1:0]  headroom_q16;
      logic [DECAY_W-1:0] decay_q16;
   } lrm_cfg_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [RATE_W-1:0] peak;
      logic [PCT_W-1:0]  pct;
   } lrm_res_type;

endpackage

`default_nettype wire

// File: sv/lrm_lane.sv
// One direction of the link rate meter: serial counter subtract, serial
// multiply and restoring divide, peak hold and auto-scale. Uses lrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrm_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      have_prev,
   input  logic [lrm_pkg::CNT_W-1:0] count,
   input  logic [lrm_pkg::MS_W-1:0]  ms,
   input  lrm_pkg::lrm_cfg_type      cfg,
   output logic                      busy,
   output lrm_pkg::lrm_res_type      res
);
   import lrm_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SUB    = 4'd1;
   localparam logic [3:0] ST_RSEL   = 4'd2;
   localparam logic [3:0] ST_MUL    = 4'd3;
   localparam logic [3:0] ST_MULEND = 4'd4;
   localparam logic [3:0] ST_DIV    = 4'd5;
   localparam logic [3:0] ST_DIVEND = 4'd6;
   localparam logic [3:0] ST_PEAK   = 4'd7;
   localparam logic [3:0] ST_PCT    = 4'd8;

   localparam logic [1:0] OP_RATE  = 2'd0;
   localparam logic [1:0] OP_HEAD  = 2'd1;
   localparam logic [1:0] OP_DECAY = 2'd2;
   localparam logic [1:0] OP_PCT   = 2'd3;

   localparam int CNT_IDX_W = $clog2(CNT_W);
   localparam int PROD_W    = MUL_S_W + MUL_F_W;

   // control state
   logic [3:0]           state_ff, state_in;
   logic [CNT_IDX_W-1:0] cnt_ff, cnt_in;
   logic [1:0]           op_ff, op_in;
   // architectural state
   logic [CNT_W-1:0]     prev_ff, prev_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [RATE_W-1:0]    peak_ff, peak_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   // datapath
   logic                 have_prev_ff, have_prev_in;
   logic [MS_W-1:0]      ms_ff, ms_in;
   logic [CNT_W-1:0]     cur_sr_ff, cur_sr_in;
   logic                 borrow_ff, borrow_in;
   logic [MUL_S_W-1:0]   mul_s_ff, mul_s_in;
   logic [MUL_F_W-1:0]   mul_f_ff, mul_f_in;
   logic [MUL_S_W-1:0]   mul_acc_ff, mul_acc_in;
   logic [MUL_F_W-1:0]   mul_lo_ff, mul_lo_in;
   logic [CNT_W-1:0]     div_q_ff, div_q_in;
   logic [SCALE_W-1:0]   div_rem_ff, div_rem_in;
   logic [SCALE_W-1:0]   div_d_ff, div_d_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;

   logic                 sub_diff, sub_borrow;
   logic [MUL_S_W:0]     mul_sum;
   logic [PROD_W-1:0]    mul_prod;
   logic [SCALE_W-1:0]   q16_res;
   logic [SCALE_W:0]     div_sh;
   logic [SCALE_W+1:0]   div_diff;
   logic                 div_ge;
   logic [SCALE_W-1:0]   rate_wide;
   logic [SCALE_W-1:0]   floor_wide;

   // bit-serial subtract, LSB first
   assign sub_diff   = cur_sr_ff[0] ^ prev_ff[0] ^ borrow_ff;
   assign sub_borrow = (~cur_sr_ff[0] & prev_ff[0]) |
                       (~(cur_sr_ff[0] ^ prev_ff[0]) & borrow_ff);

   // shift-right multiplier, one multiplier bit a cycle
   assign mul_sum  = {1'b0, mul_acc_ff} + (mul_f_ff[0] ? {1'b0, mul_s_ff} : '0);
   assign mul_prod = {mul_acc_ff, mul_lo_ff};
   assign q16_res  = (|mul_prod[PROD_W-1:SCALE_W+Q_FRAC]) ? SCALE_MAX
                   : mul_prod[SCALE_W+Q_FRAC-1:Q_FRAC];

   // restoring divider, one quotient bit a cycle
   assign div_sh   = {div_rem_ff, div_q_ff[CNT_W-1]};
   assign div_diff = {1'b0, div_sh} - {2'b0, div_d_ff};
   assign div_ge   = ~div_diff[SCALE_W+1];

   assign rate_wide  = SCALE_W'(rate_ff);
   assign floor_wide = SCALE_W'(cfg.scale_floor);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      prev_in      = prev_ff;
      rate_in      = rate_ff;
      peak_in      = peak_ff;
      scale_in     = scale_ff;
      have_prev_in = have_prev_ff;
      ms_in        = ms_ff;
      cur_sr_in    = cur_sr_ff;
      borrow_in    = borrow_ff;
      mul_s_in     = mul_s_ff;
      mul_f_in     = mul_f_ff;
      mul_acc_in   = mul_acc_ff;
      mul_lo_in    = mul_lo_ff;
      div_q_in     = div_q_ff;
      div_rem_in   = div_rem_ff;
      div_d_in     = div_d_ff;
      pct_in       = pct_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cur_sr_in    = count;
               ms_in        = ms;
               have_prev_in = have_prev;
               borrow_in    = 1'b0;
               cnt_in       = '0;
               state_in     = ST_SUB;
            end
         end
         ST_SUB: begin
            // delta shifts into the divider register; prev takes the new count
            div_q_in  = {sub_diff, div_q_ff[CNT_W-1:1]};
            prev_in   = {cur_sr_ff[0], prev_ff[CNT_W-1:1]};
            cur_sr_in = {1'b0, cur_sr_ff[CNT_W-1:1]};
            borrow_in = sub_borrow;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_IDX_W'(CNT_W - 1)) begin
               state_in = ST_RSEL;
            end
         end
         ST_RSEL: begin
            state_in = ST_PEAK;
            if (have_prev_ff) begin
               if (borrow_ff) begin
                  rate_in = '0;             // counter went backwards
               end else if (|div_q_ff[CNT_W-1:MUL_S_W]) begin
                  rate_in = RATE_MAX;       // delta would not fit the multiplicand
               end else begin
                  mul_s_in   = div_q_ff[MUL_S_W-1:0];
                  mul_f_in   = K_MS_PER_S;
                  mul_acc_in = '0;
                  cnt_in     = '0;
                  op_in      = OP_RATE;
                  state_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            mul_acc_in = mul_sum[MUL_S_W:1];
            mul_lo_in  = {mul_sum[0], mul_lo_ff[MUL_F_W-1:1]};
            mul_f_in   = {1'b0, mul_f_ff[MUL_F_W-1:1]};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CNT_IDX_W'(MUL_F_W - 1)) begin
               state_in = ST_MULEND;
            end
         end
         ST_MULEND: begin
            case (op_ff)
               OP_RATE: begin
                  div_q_in   = mul_prod[CNT_W-1:0];
                  div_d_in   = SCALE_W'(ms_ff);
                  div_rem_in = '0;
                  cnt_in     = '0;
                  state_in   = ST_DIV;
               end
               OP_HEAD: begin
                  mul_s_in   = MUL_S_W'(q16_res);
                  mul_f_in   = MUL_F_W'(cfg.decay_q16);
                  mul_acc_in = '0;
                  cnt_in     = '0;
                  op_in      = OP_DECAY;
                  state_in   = ST_MUL;
               end
               OP_DECAY: begin
                  scale_in = (q16_res < floor_wide) ? floor_wide : q16_res;
                  state_in = ST_PCT;
               end
               OP_PCT: begin
                  div_q_in   = mul_prod[CNT_W-1:0];
                  div_d_in   = scale_ff;
                  div_rem_in = '0;
                  cnt_in     = '0;
                  state_in   = ST_DIV;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DIV: begin
            div_rem_in = div_ge ? div_diff[SCALE_W-1:0] : div_sh[SCALE_W-1:0];
            div_q_in   = {div_q_ff[CNT_W-2:0], div_ge};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CNT_IDX_W'(CNT_W - 1)) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            if (op_ff == OP_RATE) begin
               rate_in  = (|div_q_ff[CNT_W-1:RATE_W]) ? RATE_MAX
                        : div_q_ff[RATE_W-1:0];
               state_in = ST_PEAK;
            end else begin
               pct_in   = ((|div_q_ff[CNT_W-1:PCT_W]) ||
                           (div_q_ff[PCT_W-1:0] > PCT_FULL)) ? PCT_FULL
                        : div_q_ff[PCT_W-1:0];
               state_in = ST_IDLE;
            end
         end
         ST_PEAK: begin
            if (rate_ff > peak_ff) begin
               peak_in = rate_ff;
            end
            mul_acc_in = '0;
            cnt_in     = '0;
            state_in   = ST_MUL;
            if (rate_wide > scale_ff) begin
               mul_s_in = MUL_S_W'(rate_ff);
               mul_f_in = cfg.headroom_q16;
               op_in    = OP_HEAD;
            end else begin
               mul_s_in = MUL_S_W'(scale_ff);
               mul_f_in = MUL_F_W'(cfg.decay_q16);
               op_in    = OP_DECAY;
            end
         end
         ST_PCT: begin
            if (scale_ff == '0) begin
               pct_in   = (rate_ff != '0) ? PCT_FULL : '0;
               state_in = ST_IDLE;
            end else if (rate_wide >= scale_ff) begin
               pct_in   = PCT_FULL;
               state_in = ST_IDLE;
            end else begin
               mul_s_in   = MUL_S_W'(rate_ff);
               mul_f_in   = K_PCT_SCALE;
               mul_acc_in = '0;
               cnt_in     = '0;
               op_in      = OP_PCT;
               state_in   = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         op_ff    <= OP_RATE;
         prev_ff  <= '0;
         rate_ff  <= '0;
         peak_ff  <= '0;
         scale_ff <= SCALE_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
         prev_ff  <= prev_in;
         rate_ff  <= rate_in;
         peak_ff  <= peak_in;
         scale_ff <= scale_in;
      end
   end

   always_ff @(posedge clock) begin
      have_prev_ff <= have_prev_in;
      ms_ff        <= ms_in;
      cur_sr_ff    <= cur_sr_in;
      borrow_ff    <= borrow_in;
      mul_s_ff     <= mul_s_in;
      mul_f_ff     <= mul_f_in;
      mul_acc_ff   <= mul_acc_in;
      mul_lo_ff    <= mul_lo_in;
      div_q_ff     <= div_q_in;
      div_rem_ff   <= div_rem_in;
      div_d_ff     <= div_d_in;
      pct_ff       <= pct_in;
   end

   assign busy     = (state_ff != ST_IDLE);
   assign res.rate = rate_ff;
   assign res.peak = peak_ff;
   assign res.pct  = pct_ff;

endmodule

`default_nettype wire

// File: sv/link_rate_meter_autoscale_top.sv
// Top level of the link rate meter with peak hold and auto-scale.
// Uses lrm_pkg and two lrm_lane instances (receive and transmit).
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+--------------------------------
//   req_     | in        | tvalid / tready   | rx_count, tx_count, elapsed_ms
//   rsp_     | out       | tvalid / tready   | rates, peaks, percents
//   csr_     | in        | we (no wait)      | addr = register index, wdata
//
// Both directions run side by side. The longest path from the accepted
// beat to the result beat is a serial subtract, two restoring divides
// and four serial multiplies in each lane. The first sample after
// reset skips the rate divide. A new sample is taken once both lanes
// are done and their results sit in the output register; a stalled
// rsp_ holds that register and does not block the next req_ beat.
// Reset is synchronous, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module link_rate_meter_autoscale_top (
   input  logic                           clock,
   input  logic                           reset,
   // rx_count [63:0], tx_count [127:64], elapsed_ms [143:128]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lrm_pkg::REQ_W-1:0]      req_tdata,
   // rx_rate [39:0], tx_rate [79:40], rx_peak [119:80], tx_peak [159:120],
   // rx_percent [173:160], tx_percent [187:174], zero [191:188]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lrm_pkg::RSP_W-1:0]      rsp_tdata,
   // register write port
   input  logic                           csr_we,
   input  logic [lrm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lrm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lrm_pkg::*;

   // config registers
   logic [MINMS_W-1:0] min_elapsed_ff;
   lrm_cfg_type        cfg_ff;

   // control
   logic               busy_ff, busy_in;
   logic               have_prev_ff, have_prev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               req_beat;
   logic [CNT_W-1:0]   rx_count, tx_count;
   logic [MS_W-1:0]    elapsed_ms;
   logic [MS_W-1:0]    ms_floor;
   logic [MS_W-1:0]    ms_used;
   logic               rx_busy, tx_busy;
   lrm_res_type        rx_res, tx_res;
   logic               load_rsp;

   assign rx_count   = req_tdata[CNT_W-1:0];
   assign tx_count   = req_tdata[2*CNT_W-1:CNT_W];
   assign elapsed_ms = req_tdata[2*CNT_W+MS_W-1:2*CNT_W];

   assign req_tready = ~busy_ff & ~reset;
   assign req_beat   = req_tvalid & req_tready;

   // a zero minimum counts as 1 ms
   assign ms_floor = (min_elapsed_ff == '0) ? MS_W'(1) : MS_W'(min_elapsed_ff);
   assign ms_used  = (elapsed_ms < ms_floor) ? ms_floor : elapsed_ms;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_elapsed_ff      <= MINMS_RESET;
         cfg_ff.scale_floor  <= FLOOR_RESET;
         cfg_ff.headroom_q16 <= HEAD_RESET;
         cfg_ff.decay_q16    <= DECAY_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MIN_ELAPSED: min_elapsed_ff      <= csr_wdata[MINMS_W-1:0];
            CSR_SCALE_FLOOR: cfg_ff.scale_floor  <= csr_wdata[FLOOR_W-1:0];
            CSR_HEADROOM:    cfg_ff.headroom_q16 <= csr_wdata[HEAD_W-1:0];
            CSR_DECAY:       cfg_ff.decay_q16    <= csr_wdata[DECAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lrm_lane u_rx_lane (
      .clock     (clock),
      .reset     (reset),
      .start     (req_beat),
      .have_prev (have_prev_ff),
      .count     (rx_count),
      .ms        (ms_used),
      .cfg       (cfg_ff),
      .busy      (rx_busy),
      .res       (rx_res)
   );

   lrm_lane u_tx_lane (
      .clock     (clock),
      .reset     (reset),
      .start     (req_beat),
      .have_prev (have_prev_ff),
      .count     (tx_count),
      .ms        (ms_used),
      .cfg       (cfg_ff),
      .busy      (tx_busy),
      .res       (tx_res)
   );

   // lanes hold their results until the next start, so a busy output
   // register just delays the hand-over
   assign load_rsp = busy_ff & ~rx_busy & ~tx_busy & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      busy_in      = busy_ff;
      have_prev_in = have_prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_beat) begin
         busy_in      = 1'b1;
         have_prev_in = 1'b1;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, tx_res.pct, rx_res.pct,
                         tx_res.peak, rx_res.peak, tx_res.rate, rx_res.rate};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/lrm_checker.sv
// Port-level checks for the link rate meter top, bound onto it below.
// Uses lrm_pkg and the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
`default_nettype none

module lrm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [lrm_pkg::RSP_W-1:0] rsp_tdata
);
   import lrm_pkg::*;

   logic req_beat, rsp_stall, pct_ok, peak_ok;

   assign req_beat  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign pct_ok    = (rsp_tdata[173:160] <= PCT_FULL) &&
                      (rsp_tdata[187:174] <= PCT_FULL);
   assign peak_ok   = (rsp_tdata[119:80] >= rsp_tdata[39:0]) &&
                      (rsp_tdata[159:120] >= rsp_tdata[79:40]);

   `LRM_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "rsp stall broken")
   `LRM_ASSERT(a_one_at_a_time, clock, reset, req_beat |=> !req_tready, "sample taken while busy")
   `LRM_ASSERT(a_pct_cap, clock, reset, rsp_tvalid |-> pct_ok, "percent above full scale")
   `LRM_ASSERT(a_peak_ge_rate, clock, reset, rsp_tvalid |-> peak_ok, "peak below rate")
   `LRM_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind link_rate_meter_autoscale_top lrm_checker u_lrm_checker (.*);

`default_nettype wire

// File: tb/link_rate_meter_autoscale_top_tb.sv
// Self-checking bench for link_rate_meter_autoscale_top: counter samples go in on req_,
// and every rsp_ beat is checked against an in-bench rate, peak and auto-scale predictor.
// Depends on lrm_pkg and the top level only.
`timescale 1ns / 1ps

module link_rate_meter_autoscale_top_tb;
   import lrm_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 180;
   localparam int DRAIN_WAIT  = 300;
   localparam int PLAN_LEN    = 29;

   typedef struct packed {
      logic [RATE_W-1:0] rx_rate;
      logic [RATE_W-1:0] tx_rate;
      logic [RATE_W-1:0] rx_peak;
      logic [RATE_W-1:0] tx_peak;
      logic [PCT_W-1:0]  rx_pct;
      logic [PCT_W-1:0]  tx_pct;
   } meter_beat_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} plan_kind_type;

   typedef struct packed {
      plan_kind_type         kind;
      logic [CSR_ADDR_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic [CNT_W-1:0]      rx;
      logic [CNT_W-1:0]      tx;
      logic [MS_W-1:0]       ms;
      logic                  known;   // want holds a hand-typed result
      meter_beat_type        want;
   } plan_row_type;

   localparam meter_beat_type ZERO_BEAT = '0;

   // Directed part. Write rows wait for the meter to go idle first.
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // first sample after reset only stores the counters
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd0, 64'd0, 16'd0, 1'b1, ZERO_BEAT},
      // no movement: rates, peaks and percents stay zero
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd0, 64'd0, 16'd1000, 1'b1, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd1000, 64'd5000, 16'd1000, 1'b0, ZERO_BEAT},
      // rx delta reaches 2^54, tx saturates through the divide
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h0040_0000_0000_03E8, 64'h0004_0000_0000_1388, 16'd10, 1'b0, ZERO_BEAT},
      // counters went backwards
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd5, 64'd3, 16'd100, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd0, 64'd0, 16'd1, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd123, 64'd0, 16'd3, 1'b0, ZERO_BEAT},
      // zero minimum acts as 1 ms
      '{ROW_WRITE, CSR_MIN_ELAPSED, 32'd0, 64'd0, 64'd0, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd126, 64'd1, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_WRITE, CSR_MIN_ELAPSED, 32'd1023, 64'd0, 64'd0, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd1126, 64'd2024, 16'd5, 1'b0, ZERO_BEAT},
      // zero floor and zero decay: scale collapses to zero
      '{ROW_WRITE, CSR_SCALE_FLOOR, 32'd0, 64'd0, 64'd0, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_WRITE, CSR_DECAY, 32'd0, 64'd0, 64'd0, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd1126, 64'd2024, 16'd500, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0, 64'd2126, 64'd2024, 16'd500, 1'b0, ZERO_BEAT},
      // max headroom and decay above 1.0: scale climbs into saturation
      '{ROW_WRITE, CSR_HEADROOM, 32'd262143, 64'd0, 64'd0, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_WRITE, CSR_DECAY, 32'd131071, 64'd0, 64'd0, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_WRITE, CSR_SCALE_FLOOR, 32'hFFFF_FFFF, 64'd0, 64'd0, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h0020_0000_0000_084E, 64'h0000_0100_0000_07E8, 16'd1, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h0040_0000_0000_084E, 64'h0000_0200_0000_07E8, 16'd1, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h0060_0000_0000_084E, 64'h0000_0300_0000_07E8, 16'd1, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h0080_0000_0000_084E, 64'h0000_0400_0000_07E8, 16'd1, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h00A0_0000_0000_084E, 64'h0000_0500_0000_07E8, 16'd1, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h00C0_0000_0000_084E, 64'h0000_0600_0000_07E8, 16'd1, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h00E0_0000_0000_084E, 64'h0000_0700_0000_07E8, 16'd1, 1'b0, ZERO_BEAT},
      '{ROW_WRITE, CSR_HEADROOM, 32'd0, 64'd0, 64'd0, 16'd0, 1'b0, ZERO_BEAT},
      '{ROW_SAMPLE, CSR_MIN_ELAPSED, 32'd0,
        64'h0100_0000_0000_084E, 64'h0000_0800_0000_07E8, 16'd1, 1'b0, ZERO_BEAT}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_MIN_ELAPSED;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predictor copy of the registers and the meter state
   logic [MINMS_W-1:0] min_ms     = MINMS_RESET;
   logic [FLOOR_W-1:0] floor_q    = FLOOR_RESET;
   logic [HEAD_W-1:0]  headroom_q = HEAD_RESET;
   logic [DECAY_W-1:0] decay_q    = DECAY_RESET;
   logic               have_base  = 1'b0;
   logic [CNT_W-1:0]   rx_base    = '0;
   logic [CNT_W-1:0]   tx_base    = '0;
   logic [RATE_W-1:0]  rx_rate_now  = '0;
   logic [RATE_W-1:0]  tx_rate_now  = '0;
   logic [RATE_W-1:0]  rx_peak_hold = '0;
   logic [RATE_W-1:0]  tx_peak_hold = '0;
   logic [SCALE_W-1:0] rx_span    = SCALE_RESET;
   logic [SCALE_W-1:0] tx_span    = SCALE_RESET;

   meter_beat_type   rate_reports_due [$];
   logic [CNT_W-1:0] sent_rx = '0;
   logic [CNT_W-1:0] sent_tx = '0;
   bit               calm = 1'b0;   // both sides run without idling
   int               mismatches = 0;
   int               cycles = 0;

   link_rate_meter_autoscale_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [RATE_W-1:0] bytes_per_sec(input logic [CNT_W-1:0] cur,
                                                       input logic [CNT_W-1:0] prev,
                                                       input logic [MS_W-1:0] ms);
      logic [CNT_W-1:0] delta;
      logic [CNT_W-1:0] q;
      if (cur < prev) return '0;
      delta = cur - prev;
      if (delta >= (64'd1 << 54)) return RATE_MAX;
      q = (delta * 64'd1000) / 64'(ms);
      return (q > 64'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
   endfunction

   // floor(s * f / 2^16), saturated to the scale width
   function automatic logic [SCALE_W-1:0] q16_mul(input logic [SCALE_W-1:0] s,
                                                  input logic [HEAD_W-1:0] f);
      logic [SCALE_W+HEAD_W-1:0] p;
      p = ({{HEAD_W{1'b0}}, s} * {{SCALE_W{1'b0}}, f}) >> Q_FRAC;
      return (p > {{HEAD_W{1'b0}}, SCALE_MAX}) ? SCALE_MAX : p[SCALE_W-1:0];
   endfunction

   function automatic logic [SCALE_W-1:0] rescale(input logic [SCALE_W-1:0] s,
                                                  input logic [RATE_W-1:0] r);
      logic [SCALE_W-1:0] v;
      v = s;
      if (SCALE_W'(r) > v) v = q16_mul(SCALE_W'(r), headroom_q);
      v = q16_mul(v, HEAD_W'(decay_q));
      if (v < SCALE_W'(floor_q)) v = SCALE_W'(floor_q);
      return v;
   endfunction

   function automatic logic [PCT_W-1:0] share_of_span(input logic [RATE_W-1:0] r,
                                                      input logic [SCALE_W-1:0] s);
      logic [63:0] p;
      if (s == '0) return (r != '0) ? PCT_FULL : '0;
      p = (64'(r) * 64'd10000) / 64'(s);
      return (p > 64'(PCT_FULL)) ? PCT_FULL : p[PCT_W-1:0];
   endfunction

   function automatic meter_beat_type meter_advance(input logic [CNT_W-1:0] rx,
                                                    input logic [CNT_W-1:0] tx,
                                                    input logic [MS_W-1:0] ms_in);
      logic [MS_W-1:0] ms;
      logic [MS_W-1:0] lo;
      meter_beat_type  b;
      lo = (min_ms == '0) ? MS_W'(1) : MS_W'(min_ms);
      ms = (ms_in < lo) ? lo : ms_in;
      // first sample only seeds the counters; rates keep their old value
      if (have_base) begin
         rx_rate_now = bytes_per_sec(rx, rx_base, ms);
         tx_rate_now = bytes_per_sec(tx, tx_base, ms);
      end
      have_base = 1'b1;
      rx_base   = rx;
      tx_base   = tx;
      if (rx_rate_now > rx_peak_hold) rx_peak_hold = rx_rate_now;
      if (tx_rate_now > tx_peak_hold) tx_peak_hold = tx_rate_now;
      rx_span = rescale(rx_span, rx_rate_now);
      tx_span = rescale(tx_span, tx_rate_now);
      b.rx_rate = rx_rate_now;
      b.tx_rate = tx_rate_now;
      b.rx_peak = rx_peak_hold;
      b.tx_peak = tx_peak_hold;
      b.rx_pct  = share_of_span(rx_rate_now, rx_span);
      b.tx_pct  = share_of_span(tx_rate_now, tx_span);
      return b;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Entered at a falling edge; returns at the falling edge after the beat
   // was taken, with tvalid still high so back-to-back beats need no toggle.
   task automatic push_sample(input logic [CNT_W-1:0] rx, input logic [CNT_W-1:0] tx,
                              input logic [MS_W-1:0] ms, input logic known,
                              input meter_beat_type want);
      meter_beat_type guess;
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {ms, tx, rx};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      guess = meter_advance(rx, tx, ms);
      if (known) guess = want;
      rate_reports_due = {rate_reports_due, guess};
      sent_rx = rx;
      sent_tx = tx;
      @(negedge clock);
   endtask

   // Hold off the sender until every pending report has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (rate_reports_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_addr  <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      case (idx)
         CSR_MIN_ELAPSED: min_ms     = val[MINMS_W-1:0];
         CSR_SCALE_FLOOR: floor_q    = val;
         CSR_HEADROOM:    headroom_q = val[HEAD_W-1:0];
         CSR_DECAY:       decay_q    = val[DECAY_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Next cumulative count: mostly plausible growth, sometimes garbage.
   function automatic logic [CNT_W-1:0] counter_step(input logic [CNT_W-1:0] last,
                                                     input bit noisy);
      logic [CNT_W-1:0] wide;
      wide = {$urandom, $urandom};
      if (noisy) begin
         case ($urandom_range(2))
            0: return wide;
            1: return last - CNT_W'($urandom_range(1000, 1));
            default: return last;
         endcase
      end
      case ($urandom_range(9))
         0:       return last;
         1, 2, 3: return last + CNT_W'($urandom_range(65535));
         4, 5, 6: return last + CNT_W'($urandom);
         7, 8:    return last + (wide >> $urandom_range(63, 22));
         default: return last + (wide >> $urandom_range(21, 0));
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0d ns: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin : watch_rsp
      meter_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rate_reports_due.size() == 0) begin
            mismatches++;
            $display("%0d ns: result beat with no sample pending, expected none actual %0h",
                     $time, rsp_tdata);
         end else begin
            want = rate_reports_due.pop_front();
            check_field("rx_rate",    64'(want.rx_rate), 64'(rsp_tdata[39:0]));
            check_field("tx_rate",    64'(want.tx_rate), 64'(rsp_tdata[79:40]));
            check_field("rx_peak",    64'(want.rx_peak), 64'(rsp_tdata[119:80]));
            check_field("tx_peak",    64'(want.tx_peak), 64'(rsp_tdata[159:120]));
            check_field("rx_percent", 64'(want.rx_pct),  64'(rsp_tdata[173:160]));
            check_field("tx_percent", 64'(want.tx_pct),  64'(rsp_tdata[187:174]));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : run
      int               i;
      int               phase;
      int               n;
      bit               noisy;
      logic [CNT_W-1:0] rx_next;
      logic [CNT_W-1:0] tx_next;
      logic [MS_W-1:0]  ms_next;
      logic [CSR_DATA_W-1:0] cfg_min;
      logic [CSR_DATA_W-1:0] cfg_floor;
      logic [CSR_DATA_W-1:0] cfg_head;
      logic [CSR_DATA_W-1:0] cfg_decay;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].kind == ROW_WRITE) begin
            wait_drained();
            write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
         end else begin
            push_sample(PLAN[i].rx, PLAN[i].tx, PLAN[i].ms, PLAN[i].known, PLAN[i].want);
         end
      end

      // Random phases, each under its own register setting.
      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         calm = (phase == 3);
         case (phase)
            0: begin
               cfg_min = 1; cfg_floor = 1; cfg_head = 65536; cfg_decay = 0;
            end
            1: begin
               cfg_min = 1000; cfg_floor = 32'hFFFF_FFFF; cfg_head = 131072;
               cfg_decay = 65536;
            end
            PHASES - 1: begin
               cfg_min   = CSR_DATA_W'(MINMS_RESET);
               cfg_floor = CSR_DATA_W'(FLOOR_RESET);
               cfg_head  = CSR_DATA_W'(HEAD_RESET);
               cfg_decay = CSR_DATA_W'(DECAY_RESET);
            end
            default: begin
               cfg_min = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 1023 : 0)
                                                 : $urandom_range(1000, 1);
               case ($urandom_range(3))
                  0:       cfg_floor = $urandom_range(1000, 0);
                  1:       cfg_floor = $urandom_range(10_000_000, 1000);
                  default: cfg_floor = $urandom;
               endcase
               cfg_head = ($urandom_range(3) == 0)
                          ? ($urandom_range(1) ? 262143 : $urandom_range(65535))
                          : $urandom_range(131072, 65536);
               cfg_decay = ($urandom_range(3) == 0) ? $urandom_range(131071, 65537)
                                                   : $urandom_range(65536);
            end
         endcase
         write_reg(CSR_MIN_ELAPSED, cfg_min);
         write_reg(CSR_SCALE_FLOOR, cfg_floor);
         write_reg(CSR_HEADROOM, cfg_head);
         write_reg(CSR_DECAY, cfg_decay);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) wait_drained();
            noisy   = ($urandom_range(99) < 20);
            rx_next = counter_step(sent_rx, noisy);
            tx_next = counter_step(sent_tx, noisy);
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: ms_next = MS_W'($urandom_range(2000, 50));
               6, 7:             ms_next = MS_W'($urandom_range(20, 0));
               8:                ms_next = MS_W'($urandom_range(65535, 1000));
               default:          ms_next = MS_W'($urandom);
            endcase
            push_sample(rx_next, tx_next, ms_next, 1'b0, ZERO_BEAT);
         end
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
